### sv/nmea_gga_position_extractor_unit_macros.svh
// ----------------------------------------------------------------------------
// nmea_gga_position_extractor_unit_macros
// Assertion shorthands shared by the position extractor RTL.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef NMEA_GGA_POSITION_EXTRACTOR_UNIT_MACROS_SVH
`define NMEA_GGA_POSITION_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define NGGA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define NGGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/nmea_gga_pkg.sv
// ----------------------------------------------------------------------------
// nmea_gga_pkg
// Characters, widths, conversion constants and the captured-field record of
// the GGA position extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_gga_pkg;

    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_W      = 8'h57;

    localparam int TAG_LEN = 6;

    localparam logic [3:0] FIELD_FIRST    = 4'd1;
    localparam logic [3:0] FIELD_LAT      = 4'd3;
    localparam logic [3:0] FIELD_LON      = 4'd5;
    localparam logic [3:0] FIELD_MAX      = 4'd15;
    localparam logic [3:0] CHAR_CNT_MAX   = 4'd15;
    localparam logic [3:0] DEG_DIGITS_LAT = 4'd2;
    localparam logic [3:0] DEG_DIGITS_LON = 4'd3;

    localparam int MIN_INT_MAX = 99;
    localparam int FRAC_MAX    = 6;

    // Widths
    localparam int DEG_W     = 10;  // up to three degree digits
    localparam int MIN_ACC_W = 27;  // minute digits, sized for six fraction digits
    localparam int FC_W      = 3;
    localparam int P10_W     = 20;
    localparam int SCALED_W  = 27;  // minutes in 1e-6 units plus bias, below 2^27
    localparam int DEG_US_W  = 30;
    localparam int QUOT_W    = 21;
    localparam int LAT_W     = 28;
    localparam int LON_W     = 31;

    localparam int USEC_PER_DEG = 1000000;
    localparam int ROUND_BIAS   = 30;

    // floor(x / 60) = floor(floor(x / 4) * DIV15_MUL / 2^DIV15_SHIFT) for x < 2^27
    localparam int          DIV_IN_W    = SCALED_W - 2;
    localparam int          DIV15_W     = 29;
    localparam logic [28:0] DIV15_MUL   = 29'd286331154;
    localparam int          DIV15_SHIFT = 32;
    localparam int          DIV_PROD_W  = DIV_IN_W + DIV15_W;

    typedef enum logic [2:0] {
        AWAIT_NONE = 3'b001,
        AWAIT_LAT  = 3'b010,
        AWAIT_LON  = 3'b100
    } await_t;

    // One closed coordinate field, as captured at its comma
    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [DEG_W-1:0]     deg;
        logic [MIN_ACC_W-1:0] minutes;
        logic [FC_W-1:0]      frac_cnt;
    } pos_field_t;

    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h24;  // $
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h47;  // G
            3'd4:    ch = 8'h47;  // G
            3'd5:    ch = 8'h41;  // A
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [P10_W-1:0] pow10(input logic [FC_W-1:0] e);
        logic [P10_W-1:0] p;
        unique case (e)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### sv/nmea_gga_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_parser
// Per-byte line tracking: tag match, field count, digit accumulation and
// capture of the latitude and longitude fields with their hemisphere.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_gga_position_extractor_unit_macros.svh"

module nmea_gga_parser #(
    parameter int MINUTE_FRAC_DIGITS = 4
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     take,
    input  wire logic [7:0]               rx_byte,
    output logic                          line_end,
    output nmea_gga_pkg::pos_field_t      lat_field,
    output nmea_gga_pkg::pos_field_t      lon_field
);
    import nmea_gga_pkg::*;

    localparam int MinW     = $clog2(100 * (10 ** MINUTE_FRAC_DIGITS));
    localparam int MinWideW = MinW + 4;

    logic                  tag_seen_reg,  tag_seen_next;
    logic [2:0]            tag_pos_reg,   tag_pos_next;
    logic [3:0]            field_num_reg, field_num_next;
    logic [3:0]            char_cnt_reg,  char_cnt_next;
    logic [DEG_W-1:0]      deg_acc_reg,   deg_acc_next;
    logic [MinW-1:0]       min_acc_reg,   min_acc_next;
    logic [FC_W-1:0]       frac_cnt_reg,  frac_cnt_next;
    logic                  point_reg,     point_next;
    await_t                await_reg,     await_next;
    pos_field_t            lat_reg,       lat_next;
    pos_field_t            lon_reg,       lon_next;

    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [3:0]            deg_digits;
    logic [MinWideW-1:0]   min_wide;
    logic                  take_nl;
    logic                  line_clear;

    assign take_nl    = take && (rx_byte == CHAR_NL);
    assign line_clear = (field_num_reg == FIELD_FIRST) && !tag_seen_reg
                        && !lat_reg.valid && !lon_reg.valid;
    assign line_end   = take_nl && tag_seen_reg;
    assign lat_field  = lat_reg;
    assign lon_field  = lon_reg;

    always_comb
    begin
        is_digit   = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
        digit_val  = is_digit ? 4'(rx_byte - CHAR_0) : 4'd0;
        deg_digits = (field_num_reg == FIELD_LON) ? DEG_DIGITS_LON : DEG_DIGITS_LAT;
        min_wide   = MinWideW'(min_acc_reg) * MinWideW'(10) + MinWideW'(digit_val);

        tag_seen_next  = tag_seen_reg;
        tag_pos_next   = tag_pos_reg;
        field_num_next = field_num_reg;
        char_cnt_next  = char_cnt_reg;
        deg_acc_next   = deg_acc_reg;
        min_acc_next   = min_acc_reg;
        frac_cnt_next  = frac_cnt_reg;
        point_next     = point_reg;
        await_next     = await_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;

        if (take)
        begin
            // hemisphere letter right after a coordinate's closing comma
            if (await_reg != AWAIT_NONE)
            begin
                if ((rx_byte == CHAR_S) || (rx_byte == CHAR_W))
                begin
                    if (await_reg == AWAIT_LAT)
                        lat_next.neg = !lat_reg.neg;
                    else
                        lon_next.neg = !lon_reg.neg;
                end
                await_next = AWAIT_NONE;
            end

            if (rx_byte == CHAR_NL)
            begin
                tag_seen_next  = 1'b0;
                tag_pos_next   = '0;
                field_num_next = FIELD_FIRST;
                char_cnt_next  = '0;
                deg_acc_next   = '0;
                min_acc_next   = '0;
                frac_cnt_next  = '0;
                point_next     = 1'b0;
                await_next     = AWAIT_NONE;
                lat_next       = '0;
                lon_next       = '0;
            end
            else
            begin
                if (!tag_seen_reg)
                begin
                    if (rx_byte == tag_char(tag_pos_reg))
                    begin
                        if (tag_pos_reg == 3'(TAG_LEN - 1))
                        begin
                            tag_seen_next = 1'b1;
                            tag_pos_next  = '0;
                        end
                        else
                            tag_pos_next = tag_pos_reg + 3'd1;
                    end
                    else
                        tag_pos_next = (rx_byte == CHAR_DOLLAR) ? 3'd1 : 3'd0;
                end

                if (rx_byte == CHAR_COMMA)
                begin
                    if (field_num_reg == FIELD_LAT)
                    begin
                        lat_next.valid    = (char_cnt_reg != 4'd0);
                        lat_next.neg      = 1'b0;
                        lat_next.deg      = deg_acc_reg;
                        lat_next.minutes  = MIN_ACC_W'(min_acc_reg);
                        lat_next.frac_cnt = frac_cnt_reg;
                        await_next        = AWAIT_LAT;
                    end
                    else if (field_num_reg == FIELD_LON)
                    begin
                        lon_next.valid    = (char_cnt_reg != 4'd0);
                        lon_next.neg      = 1'b0;
                        lon_next.deg      = deg_acc_reg;
                        lon_next.minutes  = MIN_ACC_W'(min_acc_reg);
                        lon_next.frac_cnt = frac_cnt_reg;
                        await_next        = AWAIT_LON;
                    end
                    if (field_num_reg != FIELD_MAX)
                        field_num_next = field_num_reg + 4'd1;
                    char_cnt_next = '0;
                    deg_acc_next  = '0;
                    min_acc_next  = '0;
                    frac_cnt_next = '0;
                    point_next    = 1'b0;
                end
                else
                begin
                    if (char_cnt_reg < deg_digits)
                    begin
                        if (is_digit)
                            deg_acc_next = DEG_W'(deg_acc_reg * DEG_W'(10))
                                         + DEG_W'(digit_val);
                    end
                    else if ((rx_byte == CHAR_DOT) && !point_reg)
                        point_next = 1'b1;
                    else if (is_digit)
                    begin
                        if (!point_reg)
                        begin
                            // integer minutes clamp at 99
                            if (min_wide > MinWideW'(MIN_INT_MAX))
                                min_acc_next = MinW'(MIN_INT_MAX);
                            else
                                min_acc_next = MinW'(min_wide);
                        end
                        else if (frac_cnt_reg < FC_W'(MINUTE_FRAC_DIGITS))
                        begin
                            min_acc_next  = MinW'(min_wide);
                            frac_cnt_next = frac_cnt_reg + FC_W'(1);
                        end
                    end
                    if (char_cnt_reg != CHAR_CNT_MAX)
                        char_cnt_next = char_cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_seen_reg  <= 1'b0;
            tag_pos_reg   <= '0;
            field_num_reg <= FIELD_FIRST;
            char_cnt_reg  <= '0;
            deg_acc_reg   <= '0;
            min_acc_reg   <= '0;
            frac_cnt_reg  <= '0;
            point_reg     <= 1'b0;
            await_reg     <= AWAIT_NONE;
            lat_reg       <= '0;
            lon_reg       <= '0;
        end
        else
        begin
            tag_seen_reg  <= tag_seen_next;
            tag_pos_reg   <= tag_pos_next;
            field_num_reg <= field_num_next;
            char_cnt_reg  <= char_cnt_next;
            deg_acc_reg   <= deg_acc_next;
            min_acc_reg   <= min_acc_next;
            frac_cnt_reg  <= frac_cnt_next;
            point_reg     <= point_next;
            await_reg     <= await_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
        end
    end

    `NGGA_ASSERT_SAME(a_tag_pos_range, 1'b1, tag_pos_reg < 3'(TAG_LEN), "tag position overflow")
    `NGGA_ASSERT_SAME(a_await_onehot, 1'b1, $onehot(await_reg), "hemisphere wait not one-hot")
    `NGGA_ASSERT_NEXT(a_line_clear, take_nl, line_clear, "line state not cleared after newline")

endmodule

`default_nettype wire

### sv/nmea_gga_position_extractor_unit.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_extractor_unit
// Extracts latitude and longitude from GGA sentences as signed microdegrees.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one received character (rx_byte) per
// transaction. Every character updates the line tracker in the cycle it is
// accepted; a newline that ends a line tagged $GPGGA launches one result.
// Output channel: out_valid/out_ready carry lat_valid, latitude_udeg,
// lon_valid and longitude_udeg. A field that was missing or empty reports
// valid low and a value of zero.
// Latitude and longitude are converted after the newline in a three-stage
// pipeline (minute scaling multiply, divide-by-60 reciprocal multiply, degree
// add and sign); out_valid rises once the result of its newline is in the output register.
// Throughput is one character per cycle, newlines included, while out_ready
// is high. When the receiver stalls, the pipeline fills behind the output
// register; characters are still accepted until all three stages hold a
// result, then in_ready stays low until out_ready returns.
// Reset clears the line state and all pipeline valid bits; the block starts
// waiting for a new line.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_gga_position_extractor_unit_macros.svh"

module nmea_gga_position_extractor_unit #(
    parameter int MINUTE_FRAC_DIGITS = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          rx_byte,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     lat_valid,
    output logic signed [nmea_gga_pkg::LAT_W-1:0]    latitude_udeg,
    output logic                                     lon_valid,
    output logic signed [nmea_gga_pkg::LON_W-1:0]    longitude_udeg
);
    import nmea_gga_pkg::*;

    localparam int MulW = MIN_ACC_W + P10_W;

    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [DEG_US_W-1:0] deg_us;
        logic [SCALED_W-1:0] scaled;
    } scaled_t;

    typedef struct packed {
        logic                valid;
        logic                neg;
        logic [DEG_US_W-1:0] deg_us;
        logic [QUOT_W-1:0]   quot;
    } split_t;

    logic       take;
    logic       line_end;
    pos_field_t lat_field;
    pos_field_t lon_field;

    logic    b_v_reg, c_v_reg, o_v_reg;
    logic    b_free, c_free, o_free;
    scaled_t b_lat_reg, b_lon_reg, b_lat_next, b_lon_next;
    split_t  c_lat_reg, c_lon_reg, c_lat_next, c_lon_next;

    logic                      lat_valid_reg, lon_valid_reg;
    logic signed [LAT_W-1:0]   lat_val_reg, lat_val_next;
    logic signed [LON_W-1:0]   lon_val_reg, lon_val_next;

    logic [MulW-1:0]        lat_mul, lon_mul;
    logic [DIV_PROD_W-1:0]  lat_div, lon_div;
    logic [LAT_W-1:0]       lat_abs;
    logic [LON_W-1:0]       lon_abs;
    logic                   lat_in_range;

    assign o_free   = !o_v_reg || out_ready;
    assign c_free   = !c_v_reg || o_free;
    assign b_free   = !b_v_reg || c_free;
    assign in_ready = b_free;
    assign take     = in_valid && in_ready;

    nmea_gga_parser #(
        .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .line_end  (line_end),
        .lat_field (lat_field),
        .lon_field (lon_field)
    );

    // Stage B: minutes in 1e-6 units plus rounding bias, degrees in 1e-6 units
    always_comb
    begin
        lat_mul = MulW'(lat_field.minutes)
                * MulW'(pow10(FC_W'(FRAC_MAX) - lat_field.frac_cnt));
        lon_mul = MulW'(lon_field.minutes)
                * MulW'(pow10(FC_W'(FRAC_MAX) - lon_field.frac_cnt));

        b_lat_next.valid  = lat_field.valid;
        b_lat_next.neg    = lat_field.neg;
        b_lat_next.deg_us = DEG_US_W'(DEG_US_W'(lat_field.deg) * DEG_US_W'(USEC_PER_DEG));
        b_lat_next.scaled = SCALED_W'(lat_mul) + SCALED_W'(ROUND_BIAS);

        b_lon_next.valid  = lon_field.valid;
        b_lon_next.neg    = lon_field.neg;
        b_lon_next.deg_us = DEG_US_W'(DEG_US_W'(lon_field.deg) * DEG_US_W'(USEC_PER_DEG));
        b_lon_next.scaled = SCALED_W'(lon_mul) + SCALED_W'(ROUND_BIAS);
    end

    // Stage C: divide by 60 as a shift by 2 and a reciprocal multiply by 1/15
    always_comb
    begin
        lat_div = DIV_PROD_W'(b_lat_reg.scaled[SCALED_W-1:2]) * DIV_PROD_W'(DIV15_MUL);
        lon_div = DIV_PROD_W'(b_lon_reg.scaled[SCALED_W-1:2]) * DIV_PROD_W'(DIV15_MUL);

        c_lat_next.valid  = b_lat_reg.valid;
        c_lat_next.neg    = b_lat_reg.neg;
        c_lat_next.deg_us = b_lat_reg.deg_us;
        c_lat_next.quot   = lat_div[DIV15_SHIFT +: QUOT_W];

        c_lon_next.valid  = b_lon_reg.valid;
        c_lon_next.neg    = b_lon_reg.neg;
        c_lon_next.deg_us = b_lon_reg.deg_us;
        c_lon_next.quot   = lon_div[DIV15_SHIFT +: QUOT_W];
    end

    // Output stage: combine, apply hemisphere, zero an absent field
    always_comb
    begin
        lat_abs = LAT_W'(c_lat_reg.deg_us) + LAT_W'(c_lat_reg.quot);
        lon_abs = LON_W'(c_lon_reg.deg_us) + LON_W'(c_lon_reg.quot);

        if (!c_lat_reg.valid)
            lat_val_next = '0;
        else if (c_lat_reg.neg)
            lat_val_next = $signed(LAT_W'(0) - lat_abs);
        else
            lat_val_next = $signed(lat_abs);

        if (!c_lon_reg.valid)
            lon_val_next = '0;
        else if (c_lon_reg.neg)
            lon_val_next = $signed(LON_W'(0) - lon_abs);
        else
            lon_val_next = $signed(lon_abs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
                b_v_reg <= line_end;
            if (c_free)
                c_v_reg <= b_v_reg;
            if (o_free)
                o_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && line_end)
        begin
            b_lat_reg <= b_lat_next;
            b_lon_reg <= b_lon_next;
        end
        if (c_free && b_v_reg)
        begin
            c_lat_reg <= c_lat_next;
            c_lon_reg <= c_lon_next;
        end
        if (o_free && c_v_reg)
        begin
            lat_valid_reg <= c_lat_reg.valid;
            lon_valid_reg <= c_lon_reg.valid;
            lat_val_reg   <= lat_val_next;
            lon_val_reg   <= lon_val_next;
        end
    end

    assign out_valid      = o_v_reg;
    assign lat_valid      = lat_valid_reg;
    assign lon_valid      = lon_valid_reg;
    assign latitude_udeg  = lat_val_reg;
    assign longitude_udeg = lon_val_reg;

    assign lat_in_range = (latitude_udeg <= 28'sd100666666)
                          && (latitude_udeg >= -28'sd100666666);

    `NGGA_ASSERT_NEXT(a_line_enters_pipe, line_end, b_v_reg, "line end lost")
    `NGGA_ASSERT_SAME(a_lat_zero_absent, out_valid && !lat_valid, latitude_udeg == '0, "lat nonzero")
    `NGGA_ASSERT_SAME(a_lat_range, out_valid && lat_valid, lat_in_range, "latitude out of range")

endmodule

`default_nettype wire
